// ===== hdl/lsf_pkg.sv =====
// Shared types and constants for the least-squares line fit unit.
// No dependencies; compile first.
package lsf_pkg;

  // Fixed field widths
  localparam int unsigned XW     = 9;   // point column
  localparam int unsigned YW     = 8;   // point row
  localparam int unsigned FRAC_W = 16;  // fraction bits of Q24.16
  localparam int unsigned QW     = 40;  // result word width

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  // Point accumulator sequencer
  typedef enum logic [1:0] {
    ACC_IDLE,
    ACC_MUL,
    ACC_FULL
  } lsf_acc_state_e;

  // Product sequencer
  typedef enum logic [1:0] {
    PR_IDLE,
    PR_LOAD,
    PR_MUL,
    PR_DONE
  } lsf_prod_state_e;

  // Product terms, in evaluation order
  typedef enum logic [2:0] {
    T_N_SXX,
    T_SX_SX,
    T_N_SXY,
    T_SX_SY,
    T_SXX_SY,
    T_SX_SXY
  } lsf_term_e;

  // Serial divider
  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } lsf_div_state_e;

  // Top-level result sequencer
  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_DIV_A,
    TOP_DIV_B,
    TOP_LOAD
  } lsf_top_state_e;

endpackage

// ===== hdl/lsf_point_if.sv =====
// Input channel: one point word (column, row) with valid/ready.
// Depends on lsf_pkg.
interface lsf_point_if;
  logic                     valid;
  logic                     ready;
  logic [lsf_pkg::XW-1:0]   point_x;
  logic [lsf_pkg::YW-1:0]   point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== hdl/lsf_fit_if.sv =====
// Output channel: one fit result word (slope, intercept, flag) with valid/ready.
// Depends on lsf_pkg.
interface lsf_fit_if;
  logic                          valid;
  logic                          ready;
  logic signed [lsf_pkg::QW-1:0] slope;
  logic signed [lsf_pkg::QW-1:0] intercept;
  logic                          degenerate;

  modport source (output valid, output slope, output intercept, output degenerate,
                  input ready);
  modport sink   (input valid, input slope, input intercept, input degenerate,
                  output ready);
endinterface

// ===== hdl/lsf_accum.sv =====
// Point accumulator: running sums with bit-serial x*x and x*y, one x bit per cycle.
// Depends on lsf_pkg.
module lsf_accum #(
  parameter int unsigned POINT_COUNT = 12,
  localparam int unsigned CW   = $clog2(POINT_COUNT + 1),
  localparam int unsigned NW   = $clog2(POINT_COUNT),
  localparam int unsigned SXW  = lsf_pkg::XW + CW,
  localparam int unsigned SYW  = lsf_pkg::YW + CW,
  localparam int unsigned SXXW = 2 * lsf_pkg::XW + CW,
  localparam int unsigned SXYW = lsf_pkg::XW + lsf_pkg::YW + CW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pt_valid_i,
  input  logic [lsf_pkg::XW-1:0]  pt_x_i,
  input  logic [lsf_pkg::YW-1:0]  pt_y_i,
  output logic                    pt_ready_o,
  output logic                    sum_valid_o,
  input  logic                    sum_ready_i,
  output logic [SXW-1:0]          sum_x_o,
  output logic [SYW-1:0]          sum_y_o,
  output logic [SXXW-1:0]         sum_xx_o,
  output logic [SXYW-1:0]         sum_xy_o
);

  localparam int unsigned BW  = $clog2(lsf_pkg::XW);
  localparam int unsigned XMW = 2 * lsf_pkg::XW;
  localparam int unsigned YMW = lsf_pkg::XW + lsf_pkg::YW;

  lsf_pkg::lsf_acc_state_e state_q, state_d;
  logic [NW-1:0]           cnt_q, cnt_d;
  logic [BW-1:0]           bit_q, bit_d;
  logic [SXW-1:0]          sx_q, sx_d;
  logic [SYW-1:0]          sy_q, sy_d;
  logic [SXXW-1:0]         sxx_q, sxx_d;
  logic [SXYW-1:0]         sxy_q, sxy_d;
  logic [lsf_pkg::XW-1:0]  xsh_q, xsh_d;
  logic [XMW-1:0]          xm_q, xm_d;
  logic [YMW-1:0]          ym_q, ym_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsf_pkg::ACC_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      sxy_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      sxx_q   <= sxx_d;
      sxy_q   <= sxy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xsh_q <= xsh_d;
    xm_q  <= xm_d;
    ym_q  <= ym_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sxx_d       = sxx_q;
    sxy_d       = sxy_q;
    xsh_d       = xsh_q;
    xm_d        = xm_q;
    ym_d        = ym_q;
    pt_ready_o  = 1'b0;
    sum_valid_o = 1'b0;
    unique case (state_q)
      lsf_pkg::ACC_IDLE: begin
        pt_ready_o = 1'b1;
        if (pt_valid_i) begin
          sx_d    = sx_q + SXW'(pt_x_i);
          sy_d    = sy_q + SYW'(pt_y_i);
          xsh_d   = pt_x_i;
          xm_d    = XMW'(pt_x_i);
          ym_d    = YMW'(pt_y_i);
          bit_d   = '0;
          state_d = lsf_pkg::ACC_MUL;
        end
      end
      lsf_pkg::ACC_MUL: begin
        // one multiplier bit of x per cycle
        if (xsh_q[0]) begin
          sxx_d = sxx_q + SXXW'(xm_q);
          sxy_d = sxy_q + SXYW'(ym_q);
        end
        xsh_d = xsh_q >> 1;
        xm_d  = xm_q << 1;
        ym_d  = ym_q << 1;
        bit_d = bit_q + BW'(1);
        if (bit_q == BW'(lsf_pkg::XW - 1)) begin
          if (cnt_q == NW'(POINT_COUNT - 1)) begin
            cnt_d   = '0;
            state_d = lsf_pkg::ACC_FULL;
          end else begin
            cnt_d   = cnt_q + NW'(1);
            state_d = lsf_pkg::ACC_IDLE;
          end
        end
      end
      lsf_pkg::ACC_FULL: begin
        sum_valid_o = 1'b1;
        if (sum_ready_i) begin
          sx_d    = '0;
          sy_d    = '0;
          sxx_d   = '0;
          sxy_d   = '0;
          state_d = lsf_pkg::ACC_IDLE;
        end
      end
      default: state_d = lsf_pkg::ACC_IDLE;
    endcase
  end

  assign sum_x_o  = sx_q;
  assign sum_y_o  = sy_q;
  assign sum_xx_o = sxx_q;
  assign sum_xy_o = sxy_q;

endmodule

// ===== hdl/lsf_prod.sv =====
// Product sequencer: forms denominator and both numerators with one shared
// shift-add multiplier, one multiplier bit per cycle. Depends on lsf_pkg.
module lsf_prod #(
  parameter int unsigned POINT_COUNT = 12,
  localparam int unsigned CW   = $clog2(POINT_COUNT + 1),
  localparam int unsigned SXW  = lsf_pkg::XW + CW,
  localparam int unsigned SYW  = lsf_pkg::YW + CW,
  localparam int unsigned SXXW = 2 * lsf_pkg::XW + CW,
  localparam int unsigned SXYW = lsf_pkg::XW + lsf_pkg::YW + CW,
  localparam int unsigned PW   = SXXW + SYW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 sum_valid_i,
  output logic                 sum_ready_o,
  input  logic [SXW-1:0]       sum_x_i,
  input  logic [SYW-1:0]       sum_y_i,
  input  logic [SXXW-1:0]      sum_xx_i,
  input  logic [SXYW-1:0]      sum_xy_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic signed [PW-1:0] den_o,
  output logic signed [PW-1:0] num_a_o,
  output logic signed [PW-1:0] num_b_o
);

  localparam int unsigned MW = SXW;          // widest multiplier operand
  localparam int unsigned SW = $clog2(MW);

  lsf_pkg::lsf_prod_state_e state_q, state_d;
  lsf_pkg::lsf_term_e       sel_q, sel_d;
  logic [SW-1:0]            step_q, step_d;
  logic [SXW-1:0]           sx_q, sx_d;
  logic [SYW-1:0]           sy_q, sy_d;
  logic [SXXW-1:0]          sxx_q, sxx_d;
  logic [SXYW-1:0]          sxy_q, sxy_d;
  logic [PW-1:0]            mc_q, mc_d;
  logic [MW-1:0]            mp_q, mp_d;
  logic signed [PW-1:0]     den_q, den_d;
  logic signed [PW-1:0]     na_q, na_d;
  logic signed [PW-1:0]     nb_q, nb_d;

  logic signed [PW-1:0]     acc_cur;
  logic signed [PW-1:0]     addend;
  logic signed [PW-1:0]     acc_new;
  logic                     term_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsf_pkg::PR_IDLE;
      sel_q   <= lsf_pkg::T_N_SXX;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    sxx_q <= sxx_d;
    sxy_q <= sxy_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    den_q <= den_d;
    na_q  <= na_d;
    nb_q  <= nb_d;
  end

  // accumulator selected by the current term
  always_comb begin
    term_sub = 1'b0;
    acc_cur  = den_q;
    unique case (sel_q)
      lsf_pkg::T_N_SXX:  acc_cur = den_q;
      lsf_pkg::T_SX_SX:  begin acc_cur = den_q; term_sub = 1'b1; end
      lsf_pkg::T_N_SXY:  acc_cur = na_q;
      lsf_pkg::T_SX_SY:  begin acc_cur = na_q;  term_sub = 1'b1; end
      lsf_pkg::T_SXX_SY: acc_cur = nb_q;
      lsf_pkg::T_SX_SXY: begin acc_cur = nb_q;  term_sub = 1'b1; end
      default:           acc_cur = den_q;
    endcase
    addend  = mp_q[0] ? $signed(mc_q) : '0;
    acc_new = term_sub ? (acc_cur - addend) : (acc_cur + addend);
  end

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    step_d      = step_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sxx_d       = sxx_q;
    sxy_d       = sxy_q;
    mc_d        = mc_q;
    mp_d        = mp_q;
    den_d       = den_q;
    na_d        = na_q;
    nb_d        = nb_q;
    sum_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      lsf_pkg::PR_IDLE: begin
        sum_ready_o = 1'b1;
        if (sum_valid_i) begin
          sx_d    = sum_x_i;
          sy_d    = sum_y_i;
          sxx_d   = sum_xx_i;
          sxy_d   = sum_xy_i;
          den_d   = '0;
          na_d    = '0;
          nb_d    = '0;
          sel_d   = lsf_pkg::T_N_SXX;
          state_d = lsf_pkg::PR_LOAD;
        end
      end
      lsf_pkg::PR_LOAD: begin
        step_d  = '0;
        state_d = lsf_pkg::PR_MUL;
        unique case (sel_q)
          lsf_pkg::T_N_SXX:  begin mc_d = PW'(sxx_q); mp_d = MW'(POINT_COUNT); end
          lsf_pkg::T_SX_SX:  begin mc_d = PW'(sx_q);  mp_d = MW'(sx_q);        end
          lsf_pkg::T_N_SXY:  begin mc_d = PW'(sxy_q); mp_d = MW'(POINT_COUNT); end
          lsf_pkg::T_SX_SY:  begin mc_d = PW'(sy_q);  mp_d = MW'(sx_q);        end
          lsf_pkg::T_SXX_SY: begin mc_d = PW'(sxx_q); mp_d = MW'(sy_q);        end
          lsf_pkg::T_SX_SXY: begin mc_d = PW'(sxy_q); mp_d = MW'(sx_q);        end
          default:           begin mc_d = '0;         mp_d = '0;               end
        endcase
      end
      lsf_pkg::PR_MUL: begin
        unique case (sel_q) inside
          lsf_pkg::T_N_SXX, lsf_pkg::T_SX_SX:  den_d = acc_new;
          lsf_pkg::T_N_SXY, lsf_pkg::T_SX_SY:  na_d  = acc_new;
          lsf_pkg::T_SXX_SY, lsf_pkg::T_SX_SXY: nb_d = acc_new;
          default: den_d = den_q;
        endcase
        mc_d   = mc_q << 1;
        mp_d   = mp_q >> 1;
        step_d = step_q + SW'(1);
        if (step_q == SW'(MW - 1)) begin
          state_d = lsf_pkg::PR_LOAD;
          unique case (sel_q)
            lsf_pkg::T_N_SXX:  sel_d = lsf_pkg::T_SX_SX;
            lsf_pkg::T_SX_SX:  sel_d = lsf_pkg::T_N_SXY;
            lsf_pkg::T_N_SXY:  sel_d = lsf_pkg::T_SX_SY;
            lsf_pkg::T_SX_SY:  sel_d = lsf_pkg::T_SXX_SY;
            lsf_pkg::T_SXX_SY: sel_d = lsf_pkg::T_SX_SXY;
            default:           state_d = lsf_pkg::PR_DONE;
          endcase
        end
      end
      lsf_pkg::PR_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = lsf_pkg::PR_IDLE;
      end
      default: state_d = lsf_pkg::PR_IDLE;
    endcase
  end

  assign den_o   = den_q;
  assign num_a_o = na_q;
  assign num_b_o = nb_q;

endmodule

// ===== hdl/lsf_div.sv =====
// Restoring divider, one quotient bit per cycle: (num * 2^16) / den, truncated
// toward zero and saturated to Q24.16. den must be positive. Depends on lsf_pkg.
module lsf_div #(
  parameter int unsigned PW = 35
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [PW-1:0]          num_i,
  input  logic signed [PW-1:0]          den_i,
  output logic                          done_o,
  output logic signed [lsf_pkg::QW-1:0] quot_o
);

  localparam int unsigned DW = PW + lsf_pkg::FRAC_W;   // dividend bits
  localparam int unsigned SW = $clog2(DW);
  localparam int unsigned MQ = lsf_pkg::QW - 1;         // kept quotient magnitude

  lsf_pkg::lsf_div_state_e state_q, state_d;
  logic [SW-1:0]           step_q, step_d;
  logic                    done_q, done_d;
  logic                    neg_q, neg_d;
  logic                    ovf_q, ovf_d;
  logic [PW-1:0]           dv_q, dv_d;
  logic [PW-1:0]           rem_q, rem_d;
  logic [DW-1:0]           dvd_q, dvd_d;
  logic [MQ-1:0]           q_q, q_d;

  logic [PW-1:0]           mag;
  logic [PW-1:0]           trial;
  logic                    fits;
  logic [lsf_pkg::QW-1:0]  qmag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsf_pkg::DIV_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    ovf_q <= ovf_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    q_q   <= q_d;
  end

  // remainder stays below den < 2^(PW-1), so its top bit is always clear
  assign mag   = num_i[PW-1] ? PW'(-num_i) : PW'(num_i);
  assign trial = {rem_q[PW-2:0], dvd_q[DW-1]};
  assign fits  = (trial >= dv_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    q_d     = q_q;
    unique case (state_q)
      lsf_pkg::DIV_IDLE: begin
        if (start_i) begin
          neg_d   = num_i[PW-1];
          ovf_d   = 1'b0;
          dv_d    = PW'(den_i);
          rem_d   = '0;
          dvd_d   = {mag, {lsf_pkg::FRAC_W{1'b0}}};
          q_d     = '0;
          step_d  = '0;
          state_d = lsf_pkg::DIV_RUN;
        end
      end
      lsf_pkg::DIV_RUN: begin
        rem_d  = fits ? (trial - dv_q) : trial;
        dvd_d  = dvd_q << 1;
        q_d    = {q_q[MQ-2:0], fits};
        ovf_d  = ovf_q | q_q[MQ-1];    // quotient bit beyond the saturation point
        step_d = step_q + SW'(1);
        if (step_q == SW'(DW - 1)) begin
          done_d  = 1'b1;
          state_d = lsf_pkg::DIV_IDLE;
        end
      end
      default: state_d = lsf_pkg::DIV_IDLE;
    endcase
  end

  assign qmag = {1'b0, q_q};

  always_comb begin
    if (ovf_q) quot_o = neg_q ? lsf_pkg::Q_MIN : lsf_pkg::Q_MAX;
    else       quot_o = neg_q ? -$signed(qmag) : $signed(qmag);
  end

  assign done_o = done_q;

endmodule

// ===== hdl/least_squares_line_fit_unit.sv =====
// Top level of the least-squares line fit unit: accumulator, product
// sequencer, serial divider and output register. Depends on lsf_pkg, lsf_point_if,
// lsf_fit_if, lsf_accum, lsf_prod and lsf_div.
//
// Channel   Dir  Word                                   Handshake
// --------  ---  -------------------------------------  ---------------
// point_i   in   point_x[8:0], point_y[7:0]             valid/ready
// fit_o     out  slope[39:0], intercept[39:0] (Q24.16),  valid/ready
//                degenerate
//
// Flow: the accumulator takes a point word and then multiplies shift-add, one x
// bit per cycle, with the point port closed meanwhile. After the POINT_COUNT-th
// point the product sequencer captures the sums and runs 6 terms on a multiplier
// of MW = 9 + clog2(POINT_COUNT + 1) bits, then the divider runs twice on
// dividends of PW + 16 bits, PW = 27 + 2 * clog2(POINT_COUNT + 1).
// A zero denominator skips both divisions.
// Reset clears the sums, the point count and all sequencers; no result pends.
// Stalls: the next frame's points are accepted while a result waits on fit_o;
// with that word unread a second frame waits in the divide stage, and the
// point port closes once a third frame is complete in the accumulator.
module least_squares_line_fit_unit #(
  parameter int unsigned POINT_COUNT = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsf_point_if.sink  point_i,
  lsf_fit_if.source  fit_o
);

  localparam int unsigned CW   = $clog2(POINT_COUNT + 1);
  localparam int unsigned SXW  = lsf_pkg::XW + CW;
  localparam int unsigned SYW  = lsf_pkg::YW + CW;
  localparam int unsigned SXXW = 2 * lsf_pkg::XW + CW;
  localparam int unsigned SXYW = lsf_pkg::XW + lsf_pkg::YW + CW;
  localparam int unsigned PW   = SXXW + SYW + 1;

  // accumulator -> product sequencer
  logic            sum_valid;
  logic            sum_ready;
  logic [SXW-1:0]  sum_x;
  logic [SYW-1:0]  sum_y;
  logic [SXXW-1:0] sum_xx;
  logic [SXYW-1:0] sum_xy;

  // product sequencer -> result sequencer
  logic                 prod_valid;
  logic                 prod_ready;
  logic signed [PW-1:0] den;
  logic signed [PW-1:0] num_a;
  logic signed [PW-1:0] num_b;

  // divider
  logic                          div_start;
  logic signed [PW-1:0]          div_num;
  logic                          div_done;
  logic signed [lsf_pkg::QW-1:0] div_quot;

  // result sequencer and output register
  lsf_pkg::lsf_top_state_e       state_q, state_d;
  logic                          deg_q, deg_d;
  logic signed [lsf_pkg::QW-1:0] slope_q, slope_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [lsf_pkg::QW-1:0] out_slope_q, out_slope_d;
  logic signed [lsf_pkg::QW-1:0] out_icpt_q, out_icpt_d;
  logic                          out_deg_q, out_deg_d;
  logic                          out_load;

  lsf_accum #(
    .POINT_COUNT (POINT_COUNT)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_valid_i  (point_i.valid),
    .pt_x_i      (point_i.point_x),
    .pt_y_i      (point_i.point_y),
    .pt_ready_o  (point_i.ready),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_x_o     (sum_x),
    .sum_y_o     (sum_y),
    .sum_xx_o    (sum_xx),
    .sum_xy_o    (sum_xy)
  );

  lsf_prod #(
    .POINT_COUNT (POINT_COUNT)
  ) u_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_ready_o (sum_ready),
    .sum_x_i     (sum_x),
    .sum_y_i     (sum_y),
    .sum_xx_i    (sum_xx),
    .sum_xy_i    (sum_xy),
    .res_valid_o (prod_valid),
    .res_ready_i (prod_ready),
    .den_o       (den),
    .num_a_o     (num_a),
    .num_b_o     (num_b)
  );

  lsf_div #(
    .PW (PW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // slope divides first, intercept second; den stays put until prod_ready
  assign div_num = (state_q == lsf_pkg::TOP_IDLE) ? num_a : num_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsf_pkg::TOP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q       <= deg_d;
    slope_q     <= slope_d;
    out_slope_q <= out_slope_d;
    out_icpt_q  <= out_icpt_d;
    out_deg_q   <= out_deg_d;
  end

  always_comb begin
    state_d    = state_q;
    deg_d      = deg_q;
    slope_d    = slope_q;
    div_start  = 1'b0;
    prod_ready = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      lsf_pkg::TOP_IDLE: begin
        if (prod_valid) begin
          if (den == '0) begin
            // all x equal: no division, zero outputs
            deg_d   = 1'b1;
            state_d = lsf_pkg::TOP_LOAD;
          end else begin
            deg_d     = 1'b0;
            div_start = 1'b1;
            state_d   = lsf_pkg::TOP_DIV_A;
          end
        end
      end
      lsf_pkg::TOP_DIV_A: begin
        if (div_done) begin
          slope_d   = div_quot;
          div_start = 1'b1;
          state_d   = lsf_pkg::TOP_DIV_B;
        end
      end
      lsf_pkg::TOP_DIV_B: begin
        if (div_done) state_d = lsf_pkg::TOP_LOAD;
      end
      lsf_pkg::TOP_LOAD: begin
        // wait for the output register to free up
        if (!out_valid_q || fit_o.ready) begin
          out_load   = 1'b1;
          prod_ready = 1'b1;
          state_d    = lsf_pkg::TOP_IDLE;
        end
      end
      default: state_d = lsf_pkg::TOP_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !fit_o.ready;
    out_slope_d = out_slope_q;
    out_icpt_d  = out_icpt_q;
    out_deg_d   = out_deg_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_slope_d = deg_q ? '0 : slope_q;
      out_icpt_d  = deg_q ? '0 : div_quot;
      out_deg_d   = deg_q;
    end
  end

  assign fit_o.valid      = out_valid_q;
  assign fit_o.slope      = out_slope_q;
  assign fit_o.intercept  = out_icpt_q;
  assign fit_o.degenerate = out_deg_q;

endmodule

// ===== hdl/lsf_checker.sv =====
// Port-level checks for the least-squares line fit unit, bound to the top level.
// Depends on lsf_pkg and least_squares_line_fit_unit.
module lsf_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pt_valid_i,
  input  logic                          pt_ready_i,
  input  logic                          fit_valid_i,
  input  logic                          fit_ready_i,
  input  logic signed [lsf_pkg::QW-1:0] fit_slope_i,
  input  logic signed [lsf_pkg::QW-1:0] fit_icpt_i,
  input  logic                          fit_deg_i
);

  logic pt_acc;
  assign pt_acc = pt_valid_i && pt_ready_i;

  // a stalled result word holds
  a_fit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_valid_i && !fit_ready_i |=> fit_valid_i && $stable(fit_slope_i)
      && $stable(fit_icpt_i) && $stable(fit_deg_i))
    else $error("fit word changed while stalled");

  // degenerate fit carries zero slope and intercept
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_valid_i && fit_deg_i |-> fit_slope_i == '0 && fit_icpt_i == '0)
    else $error("degenerate fit with nonzero outputs");

  // the serial multiply keeps the point port closed after each accept
  a_pt_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_acc |=> !pt_ready_i)
    else $error("point accepted during shift-add");

  // a valid result word carries no unknown bits
  a_fit_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_valid_i |-> !$isunknown({fit_slope_i, fit_icpt_i, fit_deg_i}))
    else $error("fit word has unknown bits");

endmodule

bind least_squares_line_fit_unit lsf_checker u_lsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pt_valid_i  (point_i.valid),
  .pt_ready_i  (point_i.ready),
  .fit_valid_i (fit_o.valid),
  .fit_ready_i (fit_o.ready),
  .fit_slope_i (fit_o.slope),
  .fit_icpt_i  (fit_o.intercept),
  .fit_deg_i   (fit_o.degenerate)
);

// ===== sim/least_squares_line_fit_unit_tb.sv =====
// Testbench for least_squares_line_fit_unit: drives point words, predicts each fit word and
// checks slope, intercept and the degenerate flag field by field.
// Depends on lsf_pkg, lsf_point_if, lsf_fit_if and the unit itself.
module least_squares_line_fit_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Points per fit; the unit is built with the same count.
  localparam int unsigned FRAME_POINTS = 12;
  localparam longint      FRAC_SCALE   = longint'(1) << lsf_pkg::FRAC_W;
  // Margin to run on after the last expected fit word is taken.
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES  = 2000;
  localparam int unsigned RANDOM_FRAMES = 36;

  typedef struct packed {
    logic signed [lsf_pkg::QW-1:0] slope;
    logic signed [lsf_pkg::QW-1:0] intercept;
    logic                          degenerate;
  } fit_word_t;

  // One directed point. A fit is typed in only on rows whose answer is obvious.
  typedef struct packed {
    logic [lsf_pkg::XW-1:0]        x;
    logic [lsf_pkg::YW-1:0]        y;
    logic                          has_fit;
    logic signed [lsf_pkg::QW-1:0] slope;
    logic signed [lsf_pkg::QW-1:0] intercept;
    logic                          degenerate;
  } point_row_t;

  // Point patterns for the random frames.
  typedef enum logic [2:0] {
    SHAPE_NOMINAL,   // inside the 320x240 frame
    SHAPE_FULL,      // anywhere the field widths allow
    SHAPE_VERTICAL,  // one column only: zero denominator
    SHAPE_STEEP,     // two adjacent columns, rows at the extremes
    SHAPE_LINE,      // points near a straight line
    SHAPE_OUTLIER    // one column but for a single point
  } frame_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  lsf_point_if point_if ();
  lsf_fit_if   fit_if ();

  least_squares_line_fit_unit #(
    .POINT_COUNT(FRAME_POINTS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .point_i(point_if),
    .fit_o  (fit_if)
  );

  // ---------------------------------------------------------------------------
  // Fit predictor: running sums of the current frame and the fit it yields.
  // ---------------------------------------------------------------------------
  longint      sum_x, sum_y, sum_xx, sum_xy;
  int unsigned frame_fill;
  fit_word_t   pending_fits[$];
  int unsigned fit_errors;

  // (num * 2^16) / den, truncated toward zero, clamped to Q24.16.
  function automatic logic signed [lsf_pkg::QW-1:0] q16_quotient(longint num,
                                                                  longint den);
    longint q;
    q = (num * FRAC_SCALE) / den;
    if (q > longint'(lsf_pkg::Q_MAX)) q = longint'(lsf_pkg::Q_MAX);
    if (q < longint'(lsf_pkg::Q_MIN)) q = longint'(lsf_pkg::Q_MIN);
    return q[lsf_pkg::QW-1:0];
  endfunction

  // Adds one point; returns 1 and the fit when the frame is complete.
  function automatic bit add_point(input logic [lsf_pkg::XW-1:0] x,
                                   input logic [lsf_pkg::YW-1:0] y,
                                   output fit_word_t fit);
    longint xv, yv, n, den, num_a, num_b;
    xv = longint'(x);
    yv = longint'(y);
    n  = longint'(FRAME_POINTS);
    sum_x  += xv;
    sum_y  += yv;
    sum_xx += xv * xv;
    sum_xy += xv * yv;
    frame_fill++;
    fit = '0;
    if (frame_fill < FRAME_POINTS) return 1'b0;
    den   = n * sum_xx - sum_x * sum_x;
    num_a = n * sum_xy - sum_x * sum_y;
    num_b = sum_xx * sum_y - sum_x * sum_xy;
    if (den == 0) begin
      // all columns equal: no line, flag only
      fit.degenerate = 1'b1;
    end else begin
      fit.slope     = q16_quotient(num_a, den);
      fit.intercept = q16_quotient(num_b, den);
    end
    sum_x      = 0;
    sum_y      = 0;
    sum_xx     = 0;
    sum_xy     = 0;
    frame_fill = 0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: a vertical frame at the far column (typed in: flag set,
  // zero outputs), then a frame of corner and edge points checked by the
  // predictor.
  // ---------------------------------------------------------------------------
  localparam int unsigned DIRECTED_ROWS = 24;
  point_row_t directed_rows [DIRECTED_ROWS] = '{
    '{9'd511, 8'd0,   1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd255, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd1,   1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd254, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd128, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd127, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd0,   1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd255, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd85,  1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd170, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd15,  1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd240, 1'b1, 40'sd0, 40'sd0, 1'b1},
    '{9'd0,   8'd255, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd0,   1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd0,   8'd0,   1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd255, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd319, 8'd239, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd0,   8'd128, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd511, 8'd1,   1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd256, 8'd0,   1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd255, 8'd255, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd1,   8'd254, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd510, 8'd127, 1'b0, 40'sd0, 40'sd0, 1'b0},
    '{9'd319, 8'd239, 1'b0, 40'sd0, 40'sd0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Point sender. Valid is only dropped when a gap is wanted, so back-to-back
  // words never see valid lowered and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_point(input logic [lsf_pkg::XW-1:0] x,
                            input logic [lsf_pkg::YW-1:0] y,
                            input int unsigned gap);
    if (gap > 0) begin
      point_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_if.valid   <= 1'b1;
    point_if.point_x <= x;
    point_if.point_y <= y;
    do @(posedge clk_i); while (!point_if.ready);
  endtask

  // Sends one point and queues the fit it completes, if any.
  task automatic post_point(input logic [lsf_pkg::XW-1:0] x,
                            input logic [lsf_pkg::YW-1:0] y,
                            input int unsigned gap, input bit typed,
                            input fit_word_t typed_fit);
    fit_word_t fit;
    send_point(x, y, gap);
    if (add_point(x, y, fit)) pending_fits.push_back(typed ? typed_fit : fit);
  endtask

  // ---------------------------------------------------------------------------
  // Fit receiver. Ready jitters before each word, with calm stretches,
  // and once holds off for a long time so the unit backs up onto its input.
  // ---------------------------------------------------------------------------
  initial begin : fit_receiver
    int unsigned stall;
    int unsigned taken;
    bit          calm;
    bit          held;
    taken = 0;
    calm  = 1'b0;
    held  = 1'b0;
    fit_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && taken == 5) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        fit_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      fit_if.ready <= 1'b1;
      do @(posedge clk_i); while (!fit_if.valid);
      taken++;
      if (taken % 8 == 0) calm = ($urandom_range(0, 2) == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Fit checker: every accepted word against the oldest pending fit.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : fit_checker
    fit_word_t want;
    if (rst_ni && fit_if.valid && fit_if.ready) begin
      if (pending_fits.size() == 0) begin
        $error("unexpected fit word: slope %0d intercept %0d degenerate %0b",
               fit_if.slope, fit_if.intercept, fit_if.degenerate);
        fit_errors++;
      end else begin
        want = pending_fits.pop_front();
        if (fit_if.slope !== want.slope) begin
          $error("slope: expected %0d, got %0d", want.slope, fit_if.slope);
          fit_errors++;
        end
        if (fit_if.intercept !== want.intercept) begin
          $error("intercept: expected %0d, got %0d", want.intercept, fit_if.intercept);
          fit_errors++;
        end
        if (fit_if.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate, fit_if.degenerate);
          fit_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random frames, then drain.
  // ---------------------------------------------------------------------------
  initial begin : point_stimulus
    fit_word_t    row_fit;
    frame_shape_e shape;
    int           base_x, y0, k, yl, odd_point, xi, yi;
    bit           calm;

    sum_x      = 0;
    sum_y      = 0;
    sum_xx     = 0;
    sum_xy     = 0;
    frame_fill = 0;
    fit_errors = 0;

    rst_ni           = 1'b0;
    point_if.valid   = 1'b0;
    point_if.point_x = '0;
    point_if.point_y = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row_fit.slope      = directed_rows[r].slope;
      row_fit.intercept  = directed_rows[r].intercept;
      row_fit.degenerate = directed_rows[r].degenerate;
      post_point(directed_rows[r].x, directed_rows[r].y, $urandom_range(0, 12),
                 directed_rows[r].has_fit, row_fit);
    end

    // Whole frames only, so the sums are empty once the last point is in.
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      case ($urandom_range(0, 9)) inside
        [0:2]:   shape = SHAPE_NOMINAL;
        [3:4]:   shape = SHAPE_FULL;
        5:       shape = SHAPE_VERTICAL;
        6:       shape = SHAPE_STEEP;
        [7:8]:   shape = SHAPE_LINE;
        default: shape = SHAPE_OUTLIER;
      endcase
      base_x    = $urandom_range(0, 511);
      y0        = $urandom_range(0, 255);
      k         = int'($urandom_range(0, 32)) - 16;  // slope in eighths
      odd_point = $urandom_range(0, FRAME_POINTS - 1);
      calm      = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < FRAME_POINTS; i++) begin
        case (shape)
          SHAPE_NOMINAL: begin
            xi = $urandom_range(0, 319);
            yi = $urandom_range(0, 239);
          end
          SHAPE_FULL: begin
            xi = $urandom_range(0, 511);
            yi = $urandom_range(0, 255);
          end
          SHAPE_VERTICAL: begin
            xi = base_x;
            yi = $urandom_range(0, 255);
          end
          SHAPE_STEEP: begin
            xi = (base_x % 511) + $urandom_range(0, 1);
            yi = $urandom_range(0, 1) ? 255 : 0;
          end
          SHAPE_LINE: begin
            xi = $urandom_range(0, 319);
            yl = y0 + ((xi * k) >>> 3) + int'($urandom_range(0, 4)) - 2;
            yi = (yl < 0) ? 0 : (yl > 255) ? 255 : yl;
          end
          default: begin
            xi = (i == odd_point) ? $urandom_range(0, 511) : base_x;
            yi = $urandom_range(0, 255);
          end
        endcase
        post_point(xi[lsf_pkg::XW-1:0], yi[lsf_pkg::YW-1:0],
                   calm ? 0 : $urandom_range(0, 12), 1'b0, '0);
      end
    end
    point_if.valid <= 1'b0;

    while (pending_fits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fit_errors == 0) begin
      $display("** least_squares_line_fit_unit: PASSED **");
    end else begin
      $display("** least_squares_line_fit_unit: FAILED **");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : run_limit
    #1_000_000;
    $display("** least_squares_line_fit_unit: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lsf_pkg.sv
hdl/lsf_point_if.sv
hdl/lsf_fit_if.sv
hdl/lsf_accum.sv
hdl/lsf_prod.sv
hdl/lsf_div.sv
hdl/least_squares_line_fit_unit.sv
hdl/lsf_checker.sv
sim/least_squares_line_fit_unit_tb.sv
